// ===== sv/key_value_table_insert_lookup_assert.svh =====
// Assertion macros for the key/value table RTL.
`ifndef KEY_VALUE_TABLE_INSERT_LOOKUP_ASSERT_SVH
`define KEY_VALUE_TABLE_INSERT_LOOKUP_ASSERT_SVH

// Checks a property on every rising edge of clk while reset is released.
`define KVT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a cause in one cycle is followed by an effect in the next cycle.
`define KVT_ASSERT_NEXT(lbl, cause, effect, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cause) |=> (effect)) \
		else $error(msg);

`endif

// ===== sv/kvt_pkg.sv =====
// Package with the search word type and status codes of the key/value table.
`default_nettype none
package kvt_pkg;

	localparam int KEY_W    = 32;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 3;
	localparam int OUT_IDX_W = 6;

	// Kinds of input word.
	localparam logic KIND_LOOKUP = 1'b0;
	localparam logic KIND_INSERT = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

	// Search word that walks down the row of cells.
	// data holds the insert value, or the stored value once a lookup has hit.
	typedef struct packed {
		logic              live;
		logic              kind;
		logic              found;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] data;
	} token_t;

endpackage
`default_nettype wire

// ===== sv/kvt_cell.sv =====
// One table cell: holds a key/value pair and passes the search word to the next cell.
`default_nettype none
module kvt_cell #(
	parameter int CAPACITY = 64,
	localparam int IDX_W = $clog2(CAPACITY),
	localparam int CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [IDX_W-1:0]            cell_index,
	input  logic [CNT_W-1:0]            entry_count,
	input  kvt_pkg::token_t             tok_in,
	input  logic [IDX_W-1:0]            hit_index_in,
	output kvt_pkg::token_t             tok_out,
	output logic [IDX_W-1:0]            hit_index_out,
	input  logic                        append,
	input  logic [kvt_pkg::KEY_W-1:0]   append_key,
	input  logic [kvt_pkg::DATA_W-1:0]  append_value
);
	import kvt_pkg::*;

	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] value_q;
	logic              used;
	logic              hit;
	logic              append_here;
	token_t            tok_q;
	logic [IDX_W-1:0]  hit_index_q;

	// The entry is in use when its index lies below the entry count.
	assign used        = CNT_W'(cell_index) < entry_count;
	assign hit         = tok_in.live && !tok_in.found && used && (key_q == tok_in.key);
	assign append_here = append && (CNT_W'(cell_index) == entry_count);

	// Stored pair: written by an append at this index or by an update that hits here.
	always_ff @(posedge clk) begin
		if (append_here) begin
			key_q   <= append_key;
			value_q <= append_value;
		end else if (hit && tok_in.kind == KIND_INSERT) begin
			value_q <= tok_in.data;
		end
	end

	// Hand-off register: the first hit records its index and, for a lookup, the stored value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q       <= '0;
			hit_index_q <= '0;
		end else begin
			tok_q.live  <= tok_in.live;
			tok_q.kind  <= tok_in.kind;
			tok_q.key   <= tok_in.key;
			tok_q.found <= tok_in.found || hit;
			if (hit && tok_in.kind == KIND_LOOKUP) begin
				tok_q.data <= value_q;
			end else begin
				tok_q.data <= tok_in.data;
			end
			if (hit) begin
				hit_index_q <= cell_index;
			end else begin
				hit_index_q <= hit_index_in;
			end
		end
	end

	assign tok_out       = tok_q;
	assign hit_index_out = hit_index_q;

endmodule
`default_nettype wire

// ===== sv/key_value_table_insert_lookup.sv =====
// Top level of the key/value table with insert, update and lookup by linear search.
//
//  Channel | Handshake           | Word
//  --------+---------------------+-----------------------------------
//  input   | in_valid / in_ready | kind, key, value
//  output  | out_valid/out_ready | status, entry_index, entry_value
//
// An accepted word walks the row of CAPACITY cells, one cell per cycle.
// The result enters the output register once the word has passed the last cell and the
// pending slot; a new word is taken once the last has finished, if the output is drained.
// A result held in the output register does not block the next search; only a
// second finished search waits for it. Reset empties the table (entry count zero).
`default_nettype none
`include "key_value_table_insert_lookup_assert.svh"
module key_value_table_insert_lookup #(
	parameter int CAPACITY = 64,
	localparam int IDX_W = $clog2(CAPACITY),
	localparam int CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                kind,
	input  logic signed [kvt_pkg::KEY_W-1:0]    key,
	input  logic signed [kvt_pkg::DATA_W-1:0]   value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [kvt_pkg::STATUS_W-1:0]        status,
	output logic [kvt_pkg::OUT_IDX_W-1:0]       entry_index,
	output logic signed [kvt_pkg::DATA_W-1:0]   entry_value
);
	import kvt_pkg::*;

	token_t               tok_c   [0:CAPACITY];
	logic [IDX_W-1:0]     idx_c   [0:CAPACITY];
	logic [CAPACITY-1:0]  live_vec;

	logic                 busy_q;
	logic [CNT_W-1:0]     count_q;
	logic                 pend_valid_q;
	token_t               pend_tok_q;
	logic [IDX_W-1:0]     pend_idx_q;
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [OUT_IDX_W-1:0] entry_index_q;
	logic [DATA_W-1:0]    entry_value_q;

	logic                 accept;
	logic                 finish;
	logic                 append;
	logic                 has_room;
	logic [STATUS_W-1:0]  res_status;
	logic [IDX_W-1:0]     res_index;
	logic [DATA_W-1:0]    res_value;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;

	// Head of the row: a new word enters the first cell on acceptance.
	assign tok_c[0] = '{live: accept, kind: kind, found: 1'b0, key: key, data: value};
	assign idx_c[0] = '0;

	// Row of cells, each handing the word to its right neighbor.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		kvt_cell #(.CAPACITY(CAPACITY)) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cell_index   (IDX_W'(i)),
			.entry_count  (count_q),
			.tok_in       (tok_c[i]),
			.hit_index_in (idx_c[i]),
			.tok_out      (tok_c[i+1]),
			.hit_index_out(idx_c[i+1]),
			.append       (append),
			.append_key   (pend_tok_q.key),
			.append_value (pend_tok_q.data)
		);
		assign live_vec[i] = tok_c[i+1].live;
	end

	// Result decision for the word waiting at the end of the row.
	assign has_room = count_q < CNT_W'(CAPACITY);
	assign finish   = pend_valid_q && (!out_valid_q || out_ready);

	always_comb begin
		res_status = ST_MISS;
		res_index  = '0;
		res_value  = '0;
		append     = 1'b0;
		if (pend_tok_q.found) begin
			res_status = (pend_tok_q.kind == KIND_INSERT) ? ST_UPDATED : ST_HIT;
			res_index  = pend_idx_q;
			res_value  = pend_tok_q.data;
		end else if (pend_tok_q.kind == KIND_INSERT) begin
			if (has_room) begin
				res_status = ST_INSERTED;
				res_index  = count_q[IDX_W-1:0];
				res_value  = pend_tok_q.data;
				append     = finish;
			end else begin
				res_status = ST_FULL;
			end
		end
	end

	// Control: busy flag, pending slot, entry count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (tok_c[CAPACITY].live) begin
				pend_valid_q <= 1'b1;
			end else if (finish) begin
				pend_valid_q <= 1'b0;
			end
			if (append) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Pending word captured from the last cell.
	always_ff @(posedge clk) begin
		if (tok_c[CAPACITY].live) begin
			pend_tok_q <= tok_c[CAPACITY];
			pend_idx_q <= idx_c[CAPACITY];
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (finish) begin
			status_q      <= res_status;
			entry_index_q <= OUT_IDX_W'(res_index);
			entry_value_q <= res_value;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_index = entry_index_q;
	assign entry_value = entry_value_q;

	// The entry count never passes the table size.
	`KVT_ASSERT(a_count_bound, (count_q <= CNT_W'(CAPACITY)), "entry count above capacity")
	// At most one search word is in flight, in the row or in the pending slot.
	`KVT_ASSERT(a_one_word, $onehot0({live_vec, pend_valid_q}), "more than one word in flight")
	// When idle, no word is left in the row or waiting at its end.
	`KVT_ASSERT(a_idle_empty, (!busy_q |-> (!(|live_vec) && !pend_valid_q)),
		"word in flight while idle")
	// An append grows the table by exactly one entry.
	`KVT_ASSERT_NEXT(a_append_count, append, (count_q == $past(count_q) + CNT_W'(1)),
		"append did not advance entry count")
	// A finished word always lands in the output register.
	`KVT_ASSERT_NEXT(a_finish_out, finish, out_valid_q, "finished word not shown")

endmodule
`default_nettype wire
